// ===== design/key_value_table_core_macros.svh =====
// Assertion macros shared by the key/value table RTL.
`ifndef KEY_VALUE_TABLE_CORE_MACROS_SVH
`define KEY_VALUE_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KVT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("key_value_table assertion failed");

// Next-cycle implication, disabled during reset.
`define KVT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("key_value_table assertion failed");

`endif

// ===== design/kvt_pkg.sv =====
// Shared types and constants of the key/value table.
`timescale 1ns / 1ps

package kvt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int COUNT_W     = 5;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [KEY_W-1:0] req_key;
    logic [VAL_W-1:0]        req_value;
  } kvt_req_t;

  typedef struct packed {
    logic               hit;
    logic [VAL_W-1:0]   read_value;
    logic [COUNT_W-1:0] entry_count;
    logic               full_error;
  } kvt_rsp_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_key;
    logic [VAL_W-1:0] wr_value;
  } kvt_mem_req_t;

endpackage

// ===== design/kvt_entry_store.sv =====
// Key and value storage with one write port and one registered read port.
`timescale 1ns / 1ps

module kvt_entry_store (
  input  logic                       clk_i,
  input  kvt_pkg::kvt_mem_req_t      mem_req_i,
  output logic [kvt_pkg::KEY_W-1:0]  rd_key_o,
  output logic [kvt_pkg::VAL_W-1:0]  rd_value_o
);
  import kvt_pkg::*;

  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [VAL_W-1:0] val_mem [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      key_mem[mem_req_i.wr_addr] <= mem_req_i.wr_key;
      val_mem[mem_req_i.wr_addr] <= mem_req_i.wr_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_req_i.rd_en) begin
      rd_key_o   <= key_mem[mem_req_i.rd_addr];
      rd_value_o <= val_mem[mem_req_i.rd_addr];
    end
  end

endmodule

// ===== design/key_value_table_core.sv =====
// Top level of the key/value table: request sequencer, valid bits and result register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   request | in        | in_valid_i / in_stall_o  | in_item_i  (type, key, value)
//   result  | out       | out_valid_o / out_stall_i| out_item_o (hit, value, count, full)
//
// From one acceptance to the next an item passes through S_IDLE, which accepts it,
// S_SCAN, which feeds each entry through the single key comparator from the store's
// read port and then drains the registered read, and S_UPDATE, which loads the result
// register; the next item is not accepted until the update is done.
// Reset clears the valid bits and the entry count at once; key and value
// storage needs no clearing because only valid entries are ever compared.
// A waiting result does not block acceptance of the next item; the update
// step holds only while the previous result still sits stalled.
`timescale 1ns / 1ps

module key_value_table_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kvt_pkg::kvt_req_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kvt_pkg::kvt_rsp_t out_item_o
);
  import kvt_pkg::*;

  `include "key_value_table_core_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } state_e;

  state_e           state_q;
  kvt_req_t         req_q;
  logic [CNT_W-1:0] cnt_q;        // next entry to read
  logic             rd_pend_q;    // read data for rd_idx_q arrives this cycle
  logic [IDX_W-1:0] rd_idx_q;
  logic             hit_q;
  logic [IDX_W-1:0] hit_idx_q;
  logic [VAL_W-1:0] hit_val_q;
  logic             free_q;
  logic [IDX_W-1:0] free_idx_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [CNT_W-1:0] count_q;
  logic             out_valid_q;
  kvt_rsp_t         out_q;

  kvt_mem_req_t     mem_req;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_value;

  logic             accept;
  logic             scan_match;
  logic             scan_free;
  logic             upd_go;
  kvt_rsp_t         rsp_d;
  logic [CNT_W-1:0] count_d;

  kvt_entry_store u_store (
    .clk_i      (clk_i),
    .mem_req_i  (mem_req),
    .rd_key_o   (rd_key),
    .rd_value_o (rd_value)
  );

  // Accept only while idle; an unread result does not hold off the next item.
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Update proceeds once the result register is free or being emptied.
  assign upd_go = (state_q == S_UPDATE) && !(out_valid_q && out_stall_i);

  // Shared comparator: one entry per cycle against the held key.
  assign scan_match = rd_pend_q && valid_q[rd_idx_q] && (rd_key == $unsigned(req_q.req_key));
  assign scan_free  = rd_pend_q && !valid_q[rd_idx_q];

  // Store read and write requests, and the result and count of the update step.
  always_comb begin
    rsp_d             = '0;
    count_d           = count_q;
    mem_req.rd_en     = (state_q == S_SCAN) && (cnt_q < CNT_W'(TABLE_DEPTH));
    mem_req.rd_addr   = cnt_q[IDX_W-1:0];
    mem_req.wr_en     = 1'b0;
    mem_req.wr_addr   = hit_idx_q;
    mem_req.wr_key    = $unsigned(req_q.req_key);
    mem_req.wr_value  = req_q.req_value;
    unique case (req_q.req_type)
      REQ_INSERT: begin
        rsp_d.hit = hit_q;
        if (hit_q) begin
          mem_req.wr_en = upd_go;
        end else if (free_q) begin
          mem_req.wr_en   = upd_go;
          mem_req.wr_addr = free_idx_q;
          count_d         = count_q + CNT_W'(1);
        end else begin
          rsp_d.full_error = 1'b1;
        end
      end
      REQ_LOOKUP: begin
        rsp_d.hit = hit_q;
        if (hit_q) begin
          rsp_d.read_value = hit_val_q;
        end
      end
      REQ_REMOVE: begin
        rsp_d.hit = hit_q;
        if (hit_q) begin
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
        // unused request code: report the count and change nothing
      end
    endcase
    rsp_d.entry_count = COUNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_idx_q    <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      hit_val_q   <= '0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // drop the result once taken, unless a new one loads in the same cycle
      if (out_valid_q && !out_stall_i && !upd_go) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q     <= in_item_i;
            cnt_q     <= '0;
            rd_pend_q <= 1'b0;
            hit_q     <= 1'b0;
            free_q    <= 1'b0;
            state_q   <= S_SCAN;
          end
        end
        S_SCAN: begin
          // advance the read pointer and record the first match and free slot
          rd_pend_q <= mem_req.rd_en;
          rd_idx_q  <= mem_req.rd_addr;
          if (mem_req.rd_en) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          if (scan_match && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= rd_idx_q;
            hit_val_q <= rd_value;
          end
          if (scan_free && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= rd_idx_q;
          end
          if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (upd_go) begin
            if (req_q.req_type == REQ_INSERT && !hit_q && free_q) begin
              valid_q[free_idx_q] <= 1'b1;
            end
            if (req_q.req_type == REQ_REMOVE && hit_q) begin
              valid_q[hit_idx_q] <= 1'b0;
            end
            count_q     <= count_d;
            out_q       <= rsp_d;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `KVT_ASSERT_NOW(a_count_tracks_valid, 1'b1, $countones(valid_q) == int'(count_q))
  `KVT_ASSERT_NOW(a_full_not_hit, out_valid_o && out_item_o.full_error, !out_item_o.hit)
  `KVT_ASSERT_NOW(a_value_needs_hit, out_valid_o && (out_item_o.read_value != '0), out_item_o.hit)
  `KVT_ASSERT_NEXT(a_accept_starts_scan, accept, state_q == S_SCAN)
  `KVT_ASSERT_NOW(a_no_write_in_scan, state_q == S_SCAN, !mem_req.wr_en)

endmodule

// ===== dv/key_value_table_checker.sv =====
// Result checker for the key/value table: predicts each result and compares it.
`timescale 1ns / 1ps

module key_value_table_checker
  import kvt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  kvt_req_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  kvt_rsp_t    out_item_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // Shadow copy of the table.
  logic             tbl_valid [TABLE_DEPTH];
  logic [KEY_W-1:0] tbl_key   [TABLE_DEPTH];
  logic [VAL_W-1:0] tbl_value [TABLE_DEPTH];
  int unsigned      tbl_count;

  kvt_rsp_t    expected_rsp_q [$];
  kvt_rsp_t    oldest_rsp;
  int unsigned fail_cnt;

  // Apply one request to the shadow table and return the result it causes.
  function automatic kvt_rsp_t apply_request(kvt_req_t req);
    kvt_rsp_t rsp;
    int       match;
    int       free_slot;
    rsp       = '0;
    match     = -1;
    free_slot = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tbl_valid[i] && tbl_key[i] == KEY_W'(req.req_key) && match < 0) match = i;
      if (!tbl_valid[i] && free_slot < 0) free_slot = i;
    end
    case (req.req_type)
      REQ_INSERT: begin
        if (match >= 0) begin
          rsp.hit          = 1'b1;
          tbl_value[match] = req.req_value;
        end else if (free_slot >= 0) begin
          tbl_valid[free_slot] = 1'b1;
          tbl_key[free_slot]   = KEY_W'(req.req_key);
          tbl_value[free_slot] = req.req_value;
          tbl_count++;
        end else begin
          rsp.full_error = 1'b1;
        end
      end
      REQ_LOOKUP: begin
        if (match >= 0) begin
          rsp.hit        = 1'b1;
          rsp.read_value = tbl_value[match];
        end
      end
      REQ_REMOVE: begin
        if (match >= 0) begin
          rsp.hit          = 1'b1;
          tbl_valid[match] = 1'b0;
          if (tbl_count > 0) tbl_count--;
        end
      end
      default: ;
    endcase
    rsp.entry_count = COUNT_W'(tbl_count);
    return rsp;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
      tbl_count = 0;
      fail_cnt  = 0;
      expected_rsp_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Retire the result first: it always belongs to an earlier item.
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_cnt++;
        end else begin
          oldest_rsp = expected_rsp_q.pop_front();
          check_field("hit", 32'(oldest_rsp.hit), 32'(out_item_i.hit));
          check_field("read_value", oldest_rsp.read_value, out_item_i.read_value);
          check_field("entry_count", 32'(oldest_rsp.entry_count),
                      32'(out_item_i.entry_count));
          check_field("full_error", 32'(oldest_rsp.full_error),
                      32'(out_item_i.full_error));
        end
      end
      if (in_valid_i && !in_stall_i) expected_rsp_q.push_back(apply_request(in_item_i));
      fail_count_o <= fail_cnt;
      pending_o    <= expected_rsp_q.size();
    end
  end

endmodule

// ===== dv/key_value_table_core_tb.sv =====
// Testbench top for the key/value table: stimulus, result stall, watchdog and verdict.
`timescale 1ns / 1ps

module key_value_table_core_tb;
  import kvt_pkg::*;

  // Request type the block ignores.
  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned POOL_SIZE    = 20;
  localparam int unsigned FRESH_MAX    = 8;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  kvt_req_t    in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  kvt_rsp_t    out_item;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles = 0;

  // Keys reused across requests so that hits, updates and a full table occur.
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  // Random keys that were inserted and may still sit in the table.
  logic [KEY_W-1:0] fresh_keys [$];

  key_value_table_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  key_value_table_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic kvt_req_t mk_req(input logic [1:0] op, input logic [KEY_W-1:0] key,
                                      input logic [VAL_W-1:0] value);
    kvt_req_t rq;
    rq.req_type  = op;
    rq.req_key   = key;
    rq.req_value = value;
    return rq;
  endfunction

  // Gap after an item: mostly none or short, a few long.
  function automatic int unsigned pick_gap(input bit burst);
    int unsigned r;
    r = $urandom_range(99);
    if (burst) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Present one item, hold it until accepted, then idle for the gap it is given.
  task automatic send_req(input kvt_req_t req, input int unsigned gap);
    in_item  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: stall in bursts of random length, with quiet stretches.
  initial begin : result_stall
    int unsigned r;
    int unsigned len;
    bit          level;
    forever begin
      r = $urandom_range(99);
      if (r < 45) begin
        level = 1'b0;
        len   = $urandom_range(8, 1);
      end else if (r < 80) begin
        level = 1'b1;
        len   = $urandom_range(3, 1);
      end else if (r < 92) begin
        level = 1'b1;
        len   = $urandom_range(15, 4);
      end else if (r < 96) begin
        level = 1'b1;
        len   = $urandom_range(60, 20);
      end else begin
        level = 1'b0;
        len   = $urandom_range(300, 100);
      end
      repeat (len) begin
        @(posedge clk);
        out_stall <= level;
      end
    end
  end

  // Count cycles with no accepted item on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("key_value_table_core_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned counted;
    int unsigned phase_left;
    int unsigned ins_w;
    int unsigned rem_w;
    int unsigned r;
    int unsigned pick;
    int unsigned idx;
    bit          burst;
    logic [1:0]  op;
    logic [KEY_W-1:0] key;

    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: misses on an empty table, extreme keys, fill to full,
    // insert into a full table, update while full, ignored type, remove and reuse.
    send_req(mk_req(REQ_LOOKUP, key_pool[2], '1), pick_gap(0));
    send_req(mk_req(REQ_REMOVE, key_pool[0], '1), pick_gap(0));
    send_req(mk_req(REQ_INSERT, key_pool[0], '0), pick_gap(0));
    send_req(mk_req(REQ_INSERT, key_pool[1], '1), pick_gap(0));
    send_req(mk_req(REQ_INSERT, key_pool[2], 32'ha5a5_5a5a), pick_gap(0));
    send_req(mk_req(REQ_LOOKUP, key_pool[0], '1), pick_gap(0));
    for (int i = 4; i < 17; i++) send_req(mk_req(REQ_INSERT, key_pool[i], $urandom()), 0);
    send_req(mk_req(REQ_INSERT, key_pool[3], 32'h1234_5678), pick_gap(0));
    send_req(mk_req(REQ_INSERT, key_pool[1], 32'h8765_4321), pick_gap(0));
    send_req(mk_req(REQ_LOOKUP, key_pool[1], '0), pick_gap(0));
    send_req(mk_req(REQ_UNUSED, key_pool[1], '1), pick_gap(0));
    send_req(mk_req(REQ_REMOVE, key_pool[0], '0), pick_gap(0));
    send_req(mk_req(REQ_REMOVE, key_pool[0], '0), pick_gap(0));
    send_req(mk_req(REQ_INSERT, key_pool[3], '1), pick_gap(0));
    send_req(mk_req(REQ_LOOKUP, key_pool[0], '1), pick_gap(0));

    // Random: phases biased toward filling, draining or a balanced mix.
    counted    = 0;
    phase_left = 0;
    burst      = 1'b0;
    ins_w      = 40;
    rem_w      = 30;
    while (counted < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(150, 50);
        burst      = ($urandom_range(4) == 0);
        case ($urandom_range(2))
          0: begin
            ins_w = 60;
            rem_w = 15;
          end
          1: begin
            ins_w = 15;
            rem_w = 60;
          end
          default: begin
            ins_w = 40;
            rem_w = 30;
          end
        endcase
      end
      phase_left--;

      r  = $urandom_range(99);
      op = (r < ins_w) ? REQ_INSERT : (r < 100 - rem_w) ? REQ_LOOKUP : REQ_REMOVE;
      if ($urandom_range(99) < 3) op = REQ_UNUSED;

      pick = $urandom_range(99);
      if (pick < 80) begin
        key = key_pool[$urandom_range(POOL_SIZE - 1)];
      end else if (pick < 90 || fresh_keys.size() == 0) begin
        key = $urandom();
        // Track new keys so they can be removed again; cap how many linger.
        if (op == REQ_INSERT) begin
          if (fresh_keys.size() < FRESH_MAX) fresh_keys.push_back(key);
          else op = REQ_LOOKUP;
        end
      end else begin
        idx = $urandom_range(fresh_keys.size() - 1);
        key = fresh_keys[idx];
        if (op == REQ_REMOVE) fresh_keys.delete(idx);
      end

      send_req(mk_req(op, key, pick_value()), pick_gap(burst));
      if (op != REQ_UNUSED) counted++;
    end

    // Drop valid, let the checker see the last item, then drain.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4 * TABLE_DEPTH) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("key_value_table_core_tb passed");
    end else begin
      $display("key_value_table_core_tb failed");
    end
    $finish;
  end

endmodule
